@@ hw/rtl/tks_pkg.sv @@
// tks_pkg: shared types and constants for the top-k score list.
// Used by top_k_score_list and its bench; depends on nothing.
`default_nettype none

package tks_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned TOTAL_W  = 5;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_SORT = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [SCORE_W-1:0] new_score;
    logic [3:0]                read_index;
  } req_item_t;

  typedef struct packed {
    logic                      dropped_valid;
    logic signed [SCORE_W-1:0] dropped_score;
    logic                      read_valid;
    logic signed [SCORE_W-1:0] read_score;
    logic [TOTAL_W-1:0]        entry_total;
  } rsp_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/tks_stream_if.sv @@
// tks_stream_if: valid/ready channel carrying one item of a given type.
// Item types come from tks_pkg.
`default_nettype none

interface tks_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tks_ram.sv @@
// tks_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module tks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/top_k_score_list.sv @@
// top_k_score_list: bounded list of signed scores kept in one RAM.
// Depends on tks_pkg, tks_stream_if and tks_ram.
//
//   channel | dir | payload                                        | accepted when
//   --------+-----+------------------------------------------------+------------------
//   req_i   | in  | req_type, new_score, read_index                | valid && ready
//   rsp_o   | out | dropped_valid/score, read_valid/score, total   | valid && ready
//
// Per item (n = entries before the item): a push sweeps all n entries,
// a read skips the RAM if the index is past the count, a sort runs bubble
// passes over all n entries, at most n passes (none with fewer than two
// entries), and an unused code goes straight to the response; every item
// then loads the output register. The single RAM read port sets the pace.
// Reset clears the count and control only; the RAM needs no clearing pass.
// A new item is accepted once the previous one is finished, even while its
// result still sits in the output register waiting for rsp_o.ready.
`default_nettype none

module top_k_score_list #(
  parameter int unsigned CAPACITY = tks_pkg::CAPACITY
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tks_stream_if.sink   req_i,
  tks_stream_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = tks_pkg::SCORE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SORT,
    ST_READ,
    ST_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;         // valid entries
  logic signed [SW-1:0] carry_q, carry_d;    // value carried along a sweep
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;   // next RAM read address
  logic [AW-1:0]       last_q, last_d;       // last address of the sweep
  logic                iss_q, iss_d;         // still issuing reads
  logic                pend_q, pend_d;       // read data returns this cycle
  logic [AW-1:0]       pidx_q, pidx_d;       // address of returning data
  logic                swp_q, swp_d;         // a swap occurred in this pass
  logic                full_q, full_d;       // push on a full list
  tks_pkg::rsp_item_t  res_q, res_d;
  tks_pkg::rsp_item_t  out_q, out_d;
  logic                ovld_q, ovld_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SW-1:0]       ram_rdata;
  logic signed [SW-1:0] entry;

  tks_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign entry       = $signed(ram_rdata);
  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = ovld_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    carry_d   = carry_q;
    rd_ptr_d  = rd_ptr_q;
    last_d    = last_q;
    iss_d     = iss_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    swp_d     = swp_q;
    full_d    = full_q;
    res_d     = res_q;
    out_d     = out_q;
    ovld_d    = ovld_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (ovld_q && rsp_o.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          res_d    = '0;
          carry_d  = req_i.data.new_score;
          rd_ptr_d = '0;
          pend_d   = 1'b0;
          swp_d    = 1'b0;
          last_d   = AW'(cnt_q - CW'(1));
          case (req_i.data.req_type)
            tks_pkg::REQ_PUSH: begin
              full_d  = (cnt_q == CW'(CAPACITY));
              iss_d   = (cnt_q != '0);
              state_d = ST_PUSH;
            end
            tks_pkg::REQ_SORT: begin
              if (cnt_q < CW'(2)) begin
                state_d = ST_RESP;
              end else begin
                iss_d   = 1'b1;
                state_d = ST_SORT;
              end
            end
            tks_pkg::REQ_READ: begin
              if (32'(req_i.data.read_index) < 32'(cnt_q)) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(req_i.data.read_index);
                state_d   = ST_READ;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Head-to-tail sweep: read i while writing i-1 from the
      // previous read, so read and write never hit the same entry.
      ST_PUSH: begin
        pend_d = iss_q;
        if (iss_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q;
          pidx_d    = rd_ptr_q;
          if (rd_ptr_q == last_q) begin
            iss_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + AW'(1);
          end
        end
        if (pend_q) begin
          // open list: always shift down; full list: keep the larger value
          if (!full_q || carry_q >= entry) begin
            ram_we    = 1'b1;
            ram_waddr = pidx_q;
            ram_wdata = carry_q;
            carry_d   = entry;
          end
        end else if (!iss_q) begin
          if (full_q) begin
            res_d.dropped_valid = 1'b1;
            res_d.dropped_score = carry_q;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cnt_q);
            ram_wdata = carry_q;
            cnt_d     = cnt_q + CW'(1);
          end
          state_d = ST_RESP;
        end
      end

      // One bubble pass: the carry holds the running minimum and sinks
      // to the tail; passes repeat until one makes no swap.
      ST_SORT: begin
        pend_d = iss_q;
        if (iss_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q;
          pidx_d    = rd_ptr_q;
          if (rd_ptr_q == last_q) begin
            iss_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + AW'(1);
          end
        end
        if (pend_q) begin
          if (pidx_q == '0) begin
            carry_d = entry;
          end else if (carry_q < entry) begin
            ram_we    = 1'b1;
            ram_waddr = pidx_q - AW'(1);
            ram_wdata = entry;
            swp_d     = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pidx_q - AW'(1);
            ram_wdata = carry_q;
            carry_d   = entry;
          end
        end else if (!iss_q) begin
          ram_we    = 1'b1;
          ram_waddr = last_q;
          ram_wdata = carry_q;
          if (swp_q) begin
            iss_d    = 1'b1;
            rd_ptr_d = '0;
            swp_d    = 1'b0;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_READ: begin
        res_d.read_valid = 1'b1;
        res_d.read_score = entry;
        state_d          = ST_RESP;
      end

      ST_RESP: begin
        if (!ovld_q || rsp_o.ready) begin
          out_d             = res_q;
          out_d.entry_total = tks_pkg::TOTAL_W'(cnt_q);
          ovld_d            = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
      swp_q   <= 1'b0;
      full_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      swp_q   <= swp_d;
      full_q  <= full_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q  <= carry_d;
    rd_ptr_q <= rd_ptr_d;
    last_q   <= last_d;
    pidx_q   <= pidx_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

@@ bench/tb_top_k_score_list.sv @@
// tb_top_k_score_list: self-checking bench for the top-k score list.
// Drives req items and checks rsp items against a shadow copy of the list.
// Needs tks_pkg, tks_stream_if and the top_k_score_list RTL.
`default_nettype none

module tb_top_k_score_list;
  timeunit 1ns;
  timeprecision 1ps;

  // req_type 3 has no enum member; it must leave the list untouched
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM = 1300;
  localparam logic signed [tks_pkg::SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [tks_pkg::SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n;

  tks_stream_if #(.item_t(tks_pkg::req_item_t)) req_if ();
  tks_stream_if #(.item_t(tks_pkg::rsp_item_t)) rsp_if ();

  top_k_score_list #(
    .CAPACITY(tks_pkg::CAPACITY)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // ---------------------------------------------------------------------
  // Clock: 10 ns period
  // ---------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the list. Updated the moment a req item is accepted; the
  // result it owes goes to the back of rsp_due_q.
  // ---------------------------------------------------------------------
  logic signed [tks_pkg::SCORE_W-1:0] shadow_list [tks_pkg::CAPACITY];
  int unsigned                        shadow_cnt;
  tks_pkg::rsp_item_t                 rsp_due_q [$];
  tks_pkg::req_item_t                 req_pend_q [$];

  int unsigned n_err;
  int unsigned n_acc;
  int unsigned n_rsp;
  int unsigned n_drop;
  int unsigned n_rd_hit;
  int unsigned n_sort;

  function automatic tks_pkg::rsp_item_t shadow_apply(tks_pkg::req_item_t it);
    tks_pkg::rsp_item_t                 r;
    logic signed [tks_pkg::SCORE_W-1:0] carry;
    logic signed [tks_pkg::SCORE_W-1:0] tmp;
    int                                 i;
    int                                 pass;
    r = '0;
    case (it.req_type)
      tks_pkg::REQ_PUSH: begin
        if (shadow_cnt >= tks_pkg::CAPACITY) begin
          // full: sweep from the head, larger-or-equal carry takes the slot
          carry = it.new_score;
          for (i = 0; i < int'(shadow_cnt); i++) begin
            if (carry >= shadow_list[i]) begin
              tmp            = shadow_list[i];
              shadow_list[i] = carry;
              carry          = tmp;
            end
          end
          r.dropped_valid = 1'b1;
          r.dropped_score = carry;
        end else begin
          // open slot: new score goes to the head, the rest shift down
          for (i = int'(shadow_cnt); i > 0; i--) begin
            shadow_list[i] = shadow_list[i-1];
          end
          shadow_list[0] = it.new_score;
          shadow_cnt++;
        end
      end
      tks_pkg::REQ_SORT: begin
        // bubble passes, swap only on strict less-than so ties stay put
        for (pass = 1; pass < int'(shadow_cnt); pass++) begin
          for (i = 0; i + 1 < int'(shadow_cnt); i++) begin
            if (shadow_list[i] < shadow_list[i+1]) begin
              tmp              = shadow_list[i];
              shadow_list[i]   = shadow_list[i+1];
              shadow_list[i+1] = tmp;
            end
          end
        end
      end
      tks_pkg::REQ_READ: begin
        if (it.read_index < shadow_cnt) begin
          r.read_valid = 1'b1;
          r.read_score = shadow_list[it.read_index];
        end
      end
      default: begin
      end
    endcase
    r.entry_total = tks_pkg::TOTAL_W'(shadow_cnt);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus. gen_cnt tracks the entry count so reads can be aimed at
  // live entries; the count only grows and saturates at CAPACITY.
  // ---------------------------------------------------------------------
  int unsigned gen_cnt;

  task automatic add_req(logic [1:0] kind, logic signed [tks_pkg::SCORE_W-1:0] score,
                         logic [3:0] idx);
    tks_pkg::req_item_t it;
    it.req_type   = kind;
    it.new_score  = score;
    it.read_index = idx;
    req_pend_q.push_back(it);
    if (kind == tks_pkg::REQ_PUSH && gen_cnt < tks_pkg::CAPACITY) gen_cnt++;
  endtask

  // Mix of full-range values, a narrow band that forces ties, a wider band around zero, and extremes
  function automatic logic signed [tks_pkg::SCORE_W-1:0] pick_score();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 7) return tks_pkg::SCORE_W'($urandom_range(0, 7)) - 32'sd4;
    if (sel == 7) return SCORE_MAX;
    if (sel == 8) return SCORE_MIN;
    return tks_pkg::SCORE_W'($urandom_range(0, 1000)) - 32'sd500;
  endfunction

  initial begin
    int unsigned k;
    int unsigned sel;
    logic [3:0]  idx;
    gen_cnt = 0;

    // directed: empty list corner cases
    add_req(tks_pkg::REQ_READ, 32'sd0, 4'd0);
    add_req(tks_pkg::REQ_READ, 32'sd0, 4'd15);
    add_req(tks_pkg::REQ_SORT, 32'sd0, 4'd0);
    add_req(REQ_UNUSED,        SCORE_MAX, 4'd15);
    // one entry, then two entries out of order
    add_req(tks_pkg::REQ_PUSH, SCORE_MAX, 4'd0);
    add_req(tks_pkg::REQ_SORT, 32'sd0, 4'd0);
    add_req(tks_pkg::REQ_PUSH, SCORE_MIN, 4'd0);
    add_req(tks_pkg::REQ_READ, 32'sd0, 4'd1);
    add_req(tks_pkg::REQ_SORT, SCORE_MIN, 4'd15);
    add_req(tks_pkg::REQ_READ, 32'sd0, 4'd0);
    add_req(tks_pkg::REQ_READ, 32'sd0, 4'd2);
    // fill to capacity with ties, zero, -1 and extremes
    for (k = 0; k < tks_pkg::CAPACITY - 2; k++) begin
      case (k % 4)
        0:       add_req(tks_pkg::REQ_PUSH, 32'sd0, 4'd0);
        1:       add_req(tks_pkg::REQ_PUSH, -32'sd1, 4'd0);
        2:       add_req(tks_pkg::REQ_PUSH, SCORE_MIN, 4'd0);
        default: add_req(tks_pkg::REQ_PUSH, SCORE_MAX, 4'd0);
      endcase
    end
    // full list: drop of the new value itself, then a new maximum
    add_req(tks_pkg::REQ_PUSH, SCORE_MIN, 4'd0);
    add_req(tks_pkg::REQ_PUSH, SCORE_MAX, 4'd0);
    add_req(tks_pkg::REQ_SORT, 32'sd0, 4'd0);
    add_req(tks_pkg::REQ_READ, 32'sd0, 4'd15);
    add_req(REQ_UNUSED,        SCORE_MIN, 4'd0);

    // random traffic
    for (k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        add_req(tks_pkg::REQ_PUSH, pick_score(), 4'($urandom));
      end else if (sel < 60) begin
        add_req(tks_pkg::REQ_SORT, $urandom, 4'($urandom));
      end else if (sel < 95) begin
        if (gen_cnt > 0 && $urandom_range(0, 3) != 0)
          idx = 4'($urandom_range(0, gen_cnt - 1));
        else
          idx = 4'($urandom);
        add_req(tks_pkg::REQ_READ, $urandom, idx);
      end else begin
        add_req(REQ_UNUSED, $urandom, 4'($urandom));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Reset, known input levels from time zero, and end of run
  // ---------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.data     = '0;
    rsp_if.ready    = 1'b0;
    shadow_cnt      = 0;
    n_err           = 0;
    n_acc           = 0;
    n_rsp           = 0;
    n_drop          = 0;
    n_rd_hit        = 0;
    n_sort          = 0;
    foreach (shadow_list[i]) shadow_list[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_pend_q.size() != 0) @(posedge clk);
    while (rsp_due_q.size() != 0) @(posedge clk);
    // one result per item, so nothing else should show up; watch a while
    repeat (32) @(posedge clk);

    $display("covered %0d req items, %0d rsp items checked", n_acc, n_rsp);
    $display("  %0d full-list drops, %0d live reads, %0d sorts, %0d errors",
             n_drop, n_rd_hit, n_sort, n_err);
    if (n_err == 0) begin
      $display("top_k_score_list regression: pass");
    end else begin
      $display("top_k_score_list regression: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run (all full-list sorts,
  // worst gaps and stalls on every item)
  initial begin
    #25_000_000;
    $display("top_k_score_list regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: one gap drawn per item, with calm stretches of no gaps
  // ---------------------------------------------------------------------
  int unsigned req_gap;
  bit          req_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_gap      = $urandom_range(0, 8);
      req_calm     = 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        rsp_due_q.push_back(shadow_apply(req_if.data));
        if (req_if.data.req_type == tks_pkg::REQ_SORT) n_sort++;
        void'(req_pend_q.pop_front());
        n_acc++;
        if ($urandom_range(0, 59) == 0) req_calm = !req_calm;
        req_gap = req_calm ? 0 : $urandom_range(0, 8);
      end
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (req_pend_q.size() != 0) begin
        req_if.valid <= 1'b1;
        req_if.data  <= req_pend_q[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each rsp item against the oldest owed result and
  // draws a stall before taking the next one
  // ---------------------------------------------------------------------
  int unsigned rsp_stall;
  bit          rsp_calm;

  always @(posedge clk) begin
    tks_pkg::rsp_item_t want;
    tks_pkg::rsp_item_t got;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_stall    = $urandom_range(0, 8);
      rsp_calm     = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        n_rsp++;
        if (rsp_due_q.size() == 0) begin
          $error("rsp item with no request outstanding");
          n_err++;
        end else begin
          want = rsp_due_q.pop_front();
          if (got.dropped_valid !== want.dropped_valid) begin
            $error("dropped_valid: expected %0d, got %0d",
                   want.dropped_valid, got.dropped_valid);
            n_err++;
          end
          if (got.dropped_score !== want.dropped_score) begin
            $error("dropped_score: expected %0d, got %0d",
                   want.dropped_score, got.dropped_score);
            n_err++;
          end
          if (got.read_valid !== want.read_valid) begin
            $error("read_valid: expected %0d, got %0d",
                   want.read_valid, got.read_valid);
            n_err++;
          end
          if (got.read_score !== want.read_score) begin
            $error("read_score: expected %0d, got %0d",
                   want.read_score, got.read_score);
            n_err++;
          end
          if (got.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d",
                   want.entry_total, got.entry_total);
            n_err++;
          end
          if (want.dropped_valid) n_drop++;
          if (want.read_valid) n_rd_hit++;
        end
        if ($urandom_range(0, 59) == 0) rsp_calm = !rsp_calm;
        rsp_stall = rsp_calm ? 0 : $urandom_range(0, 8);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
